// ----- rtl/core/line_raster_pixel_writer_assert.svh -----
// assertion macros shared by the line raster pixel writer checker
// depends on: nothing; expects clk_i and rst_ni in the scope of use
`ifndef LINE_RASTER_PIXEL_WRITER_ASSERT_SVH
`define LINE_RASTER_PIXEL_WRITER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define LRPW_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line raster pixel writer assertion failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define LRPW_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line raster pixel writer assertion failed");

`endif

// ----- rtl/core/lrpw_pkg.sv -----
// types, codes and colour conversion helpers for the line raster pixel writer
// depends on: nothing
package lrpw_pkg;

  // item codes
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  // pixel formats held in the format register
  typedef enum logic [1:0] {
    PF_RGB332  = 2'd0,
    PF_RGB565  = 2'd1,
    PF_RAW32   = 2'd2,
    PF_RGB565B = 2'd3
  } pix_fmt_e;

  // register indexes on the apb port
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE   = 2'd2;
  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd3;

  localparam int unsigned AddrW = 4;

  // register reset values
  localparam logic [15:0] FrameWidthRst  = 16'd320;
  localparam logic [15:0] FrameHeightRst = 16'd240;
  localparam logic [15:0] RowStrideRst   = 16'd640;

  // input beat
  typedef struct packed {
    op_e                opcode;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic        [31:0] line_color;
  } in_item_t;

  // output beat
  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               in_bounds;
    logic        [31:0] byte_address;
    logic        [31:0] pixel_value;
    logic        [2:0]  byte_count;
    logic               last_pixel;
  } out_item_t;

  // bytes per pixel
  function automatic logic [2:0] fmt_bytes(pix_fmt_e fmt);
    logic [2:0] n;
    case (fmt)
      PF_RGB332: n = 3'd1;
      PF_RAW32:  n = 3'd4;
      default:   n = 3'd2;
    endcase
    return n;
  endfunction

  // log2 of bytes per pixel, for the address shift
  function automatic logic [1:0] fmt_shift(pix_fmt_e fmt);
    logic [1:0] s;
    case (fmt)
      PF_RGB332: s = 2'd0;
      PF_RAW32:  s = 2'd2;
      default:   s = 2'd1;
    endcase
    return s;
  endfunction

  // colour packing, red 31:24, green 23:16, blue 15:8
  function automatic logic [31:0] fmt_convert(pix_fmt_e fmt, logic [31:0] c);
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [31:0] v;
    r = c[31:24];
    g = c[23:16];
    b = c[15:8];
    case (fmt)
      PF_RGB332: v = {24'd0, r[7:5], g[7:5], b[7:6]};
      PF_RAW32:  v = c;
      default:   v = {16'd0, r[7:3], g[7:2], b[7:3]};
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/line_raster_pixel_writer.sv -----
// line raster pixel writer: all-octant line stepping, clipping, address and colour
// depends on: lrpw_pkg
//
// usage
// - input channel in_item_i / in_valid_i / in_stall_o: a start beat loads both
//   endpoints and the colour and gives no output; each step beat gives one pixel
//   and advances the point; a step while no line is active is taken and dropped
// - output channel out_item_o / out_valid_o / out_stall_i: one beat per step,
//   last_pixel set on the far endpoint, after which steps are dropped again
// - apb port writes and reads the frame width, height, row stride and format;
//   writes belong to idle periods only
// - a step's pixel is registered in the output register, or in the skid on a stall
// - throughput: one beat per cycle while in_stall_o is low; the stepping state
//   updates in the same cycle the beat is taken; address uses one 16x16 multiplier
// - the output register is backed by a one-beat skid register, so in_stall_o
//   is a registered flag and rises only once both are full
// - reset: registers return to 320x240, stride 640, rgb565, and no line is active
// - a stalled output beat is held unchanged until taken
module line_raster_pixel_writer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input beats
  input  lrpw_pkg::in_item_t         in_item_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  // output beats
  output lrpw_pkg::out_item_t        out_item_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lrpw_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // configuration registers
  logic [15:0]        frame_width_q;
  logic [15:0]        frame_height_q;
  logic [15:0]        row_stride_q;
  lrpw_pkg::pix_fmt_e pixel_format_q;

  logic       cfg_write;
  logic [1:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= lrpw_pkg::FrameWidthRst;
      frame_height_q <= lrpw_pkg::FrameHeightRst;
      row_stride_q   <= lrpw_pkg::RowStrideRst;
      pixel_format_q <= lrpw_pkg::PF_RGB565;
    end else if (cfg_write) begin
      case (cfg_index)
        lrpw_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[15:0];
        lrpw_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[15:0];
        lrpw_pkg::REG_ROW_STRIDE:   row_stride_q   <= pwdata[15:0];
        default:                    pixel_format_q <= lrpw_pkg::pix_fmt_e'(pwdata[1:0]);
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_index)
      lrpw_pkg::REG_FRAME_WIDTH:  prdata = {16'd0, frame_width_q};
      lrpw_pkg::REG_FRAME_HEIGHT: prdata = {16'd0, frame_height_q};
      lrpw_pkg::REG_ROW_STRIDE:   prdata = {16'd0, row_stride_q};
      default:                    prdata = {30'd0, pixel_format_q};
    endcase
  end

  // line state
  logic signed [15:0] cur_x_q, cur_x_d;
  logic signed [15:0] cur_y_q, cur_y_d;
  logic signed [15:0] target_x_q, target_x_d;
  logic signed [15:0] target_y_q, target_y_d;
  logic [15:0]        delta_x_q, delta_x_d;
  logic [15:0]        delta_y_q, delta_y_d;
  logic               dir_x_neg_q, dir_x_neg_d;
  logic               dir_y_neg_q, dir_y_neg_d;
  logic signed [18:0] error_q, error_d;
  logic [31:0]        color_q, color_d;
  logic               active_q, active_d;

  logic in_accept;
  assign in_accept = in_valid_i & ~in_stall_o;

  // start beat set-up: magnitudes and directions
  logic signed [16:0] sx_ext, sy_ext, ex_ext, ey_ext;
  logic signed [16:0] dx_full, dy_full;
  logic signed [18:0] err_start;

  assign sx_ext = 17'(in_item_i.start_x);
  assign sy_ext = 17'(in_item_i.start_y);
  assign ex_ext = 17'(in_item_i.end_x);
  assign ey_ext = 17'(in_item_i.end_y);

  always_comb begin
    dx_full   = (ex_ext >= sx_ext) ? (ex_ext - sx_ext) : (sx_ext - ex_ext);
    dy_full   = (ey_ext >= sy_ext) ? (ey_ext - sy_ext) : (sy_ext - ey_ext);
    err_start = $signed({3'd0, dx_full[15:0]}) - $signed({3'd0, dy_full[15:0]});
  end

  // step: error rule
  logic signed [19:0] e2;
  logic               step_x, step_y;
  logic signed [18:0] err_step;
  logic               at_end;

  always_comb begin
    e2       = {error_q, 1'b0};
    step_x   = e2 > -$signed({4'd0, delta_y_q});
    step_y   = e2 < $signed({4'd0, delta_x_q});
    err_step = error_q
             - (step_x ? $signed({3'd0, delta_y_q}) : 19'sd0)
             + (step_y ? $signed({3'd0, delta_x_q}) : 19'sd0);
    at_end   = (cur_x_q == target_x_q) && (cur_y_q == target_y_q);
  end

  // next line state and result strobe
  logic res_valid;

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    target_x_d  = target_x_q;
    target_y_d  = target_y_q;
    delta_x_d   = delta_x_q;
    delta_y_d   = delta_y_q;
    dir_x_neg_d = dir_x_neg_q;
    dir_y_neg_d = dir_y_neg_q;
    error_d     = error_q;
    color_d     = color_q;
    active_d    = active_q;
    res_valid   = 1'b0;
    if (in_accept) begin
      if (in_item_i.opcode == lrpw_pkg::OP_START) begin
        cur_x_d     = in_item_i.start_x;
        cur_y_d     = in_item_i.start_y;
        target_x_d  = in_item_i.end_x;
        target_y_d  = in_item_i.end_y;
        delta_x_d   = dx_full[15:0];
        delta_y_d   = dy_full[15:0];
        dir_x_neg_d = !(sx_ext < ex_ext);
        dir_y_neg_d = !(sy_ext < ey_ext);
        error_d     = err_start;
        color_d     = in_item_i.line_color;
        active_d    = 1'b1;
      end else if (active_q) begin
        res_valid = 1'b1;
        if (at_end) begin
          active_d = 1'b0;
        end else begin
          error_d = err_step;
          if (step_x) begin
            cur_x_d = dir_x_neg_q ? cur_x_q - 16'sd1 : cur_x_q + 16'sd1;
          end
          if (step_y) begin
            cur_y_d = dir_y_neg_q ? cur_y_q - 16'sd1 : cur_y_q + 16'sd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      target_x_q  <= '0;
      target_y_q  <= '0;
      delta_x_q   <= '0;
      delta_y_q   <= '0;
      dir_x_neg_q <= 1'b0;
      dir_y_neg_q <= 1'b0;
      error_q     <= '0;
      color_q     <= '0;
      active_q    <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      target_x_q  <= target_x_d;
      target_y_q  <= target_y_d;
      delta_x_q   <= delta_x_d;
      delta_y_q   <= delta_y_d;
      dir_x_neg_q <= dir_x_neg_d;
      dir_y_neg_q <= dir_y_neg_d;
      error_q     <= error_d;
      color_q     <= color_d;
      active_q    <= active_d;
    end
  end

  // clipping, address and colour for the current point
  lrpw_pkg::out_item_t res;
  logic                in_frame;
  logic [31:0]         row_offset;
  logic [17:0]         col_offset;

  always_comb begin
    in_frame   = !cur_x_q[15] && !cur_y_q[15] &&
                 (cur_x_q[15:0] < frame_width_q) && (cur_y_q[15:0] < frame_height_q);
    row_offset = {16'd0, cur_y_q[15:0]} * {16'd0, row_stride_q};
    col_offset = {2'd0, cur_x_q[15:0]} << lrpw_pkg::fmt_shift(pixel_format_q);
    res.pixel_x      = cur_x_q;
    res.pixel_y      = cur_y_q;
    res.in_bounds    = in_frame;
    res.byte_address = in_frame ? row_offset + {14'd0, col_offset} : 32'd0;
    res.pixel_value  = lrpw_pkg::fmt_convert(pixel_format_q, color_q);
    res.byte_count   = lrpw_pkg::fmt_bytes(pixel_format_q);
    res.last_pixel   = at_end;
  end

  // output register with one-beat skid
  lrpw_pkg::out_item_t out_q, skid_q;
  logic                out_valid_q, skid_valid_q;
  logic                out_take;

  assign out_take    = out_valid_q & ~out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

endmodule

// ----- rtl/core/lrpw_checker.sv -----
// port-level checks for the line raster pixel writer, bound to the top level
// depends on: lrpw_pkg, line_raster_pixel_writer_assert.svh
`include "line_raster_pixel_writer_assert.svh"

module lrpw_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input lrpw_pkg::out_item_t        out_item_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i
);

  // a stalled output beat stays offered
  `LRPW_ASSERT_NXT(a_out_held, out_valid_o && out_stall_i, out_valid_o)

  // input backpressure only once the output register holds a beat
  `LRPW_ASSERT_IMP(a_stall_needs_out, in_stall_o, out_valid_o)

  // a clipped point never carries an address
  `LRPW_ASSERT_IMP(a_clip_addr, out_valid_o && !out_item_o.in_bounds,
                   out_item_o.byte_address == 32'd0)

  // an in-frame point has non-negative coordinates
  `LRPW_ASSERT_IMP(a_bounds_sign, out_valid_o && out_item_o.in_bounds,
                   !out_item_o.pixel_x[15] && !out_item_o.pixel_y[15])

  // pixel size is always one, two or four bytes
  `LRPW_ASSERT_IMP(a_byte_count, out_valid_o,
                   out_item_o.byte_count == 3'd1 || out_item_o.byte_count == 3'd2 ||
                   out_item_o.byte_count == 3'd4)

endmodule

bind line_raster_pixel_writer lrpw_checker u_lrpw_checker (.*);
